@@ design/lpbc_pkg.sv @@
// Shared types and codes for the LRU pinned block cache directory.
// No dependencies.
package lpbc_pkg;

   typedef enum logic [2:0] {
      REQ_GET       = 3'd0,
      REQ_PUT       = 3'd1,
      REQ_MARK_DIRTY = 3'd2,
      REQ_FLUSH_DEV = 3'd3,
      REQ_INV_BLOCK = 3'd4,
      REQ_INV_DEV   = 3'd5
   } req_code_type;

   typedef enum logic [3:0] {
      ST_HIT          = 4'd0,
      ST_FILLED       = 4'd1,
      ST_BAD_SIZE     = 4'd2,
      ST_LBA_OVERFLOW = 4'd3,
      ST_OUT_OF_RANGE = 4'd4,
      ST_ALL_PINNED   = 4'd5,
      ST_NOT_CACHED   = 4'd6,
      ST_PIN_UNDERFLOW = 4'd7,
      ST_PINNED_REFUSED = 4'd8
   } status_code_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_READ   = 2'd1,
      KIND_WRITE  = 2'd2
   } item_kind_type;

   typedef enum logic [0:0] {
      CSR_LAST_LBA = 1'd0,
      CSR_RANGE_ON = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MUL,
      S_CHECK,
      S_FILL,
      S_CMD,
      S_STAT
   } fsm_state_type;

   localparam int unsigned SECTOR_SHIFT = 9;
   localparam logic [7:0] PIN_MAX = 8'hFF;

endpackage

@@ design/lru_pinned_block_cache_directory_core.sv @@
// Top level of the LRU pinned block cache directory.
// Depends on lpbc_pkg.
//
// Usage: a request transaction on req_* (valid/ready) names a device and a
// block. The block scans its PAGES slots one per cycle through a shared
// compare path, then decides, runs at most one pass of the shared 32 x N
// multiplier (fill LBA or writeback LBA) and emits on rsp_*: an optional
// read or write command, then a final status transaction with is_last set
// and the four running counters.
// Path: after the scan of all slots a fill passes decide, multiply, check,
// fill, command and status, the longest path; other requests take shorter
// paths through a subset of these states. The idle state then accepts the
// next request.
// One request is in work at a time; req_ready is high in idle, including
// while the previous final status still sits in the output register.
// A stalled receiver holds rsp_* steady; the sequencer waits before loading
// the output register until it is free.
// Reset (synchronous, active high) empties every slot, clears the counters,
// sets device_last_lba to all ones, turns the range check on. Config writes on
// csr_* take effect at once; the user must make them only while idle (the block does not enforce it).
module lru_pinned_block_cache_directory_core #(
   parameter int PAGES = 16,
   parameter int MAX_BLOCK_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_device_id,
   input  logic [31:0] req_block_number,
   input  logic [15:0] req_block_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_item_kind,
   output logic [3:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [31:0] rsp_lba,
   output logic [3:0]  rsp_sector_count,
   output logic        rsp_is_last,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_eviction_count,
   output logic [31:0] rsp_writeback_count,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import lpbc_pkg::*;

   localparam int IW = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int SW = $clog2(MAX_BLOCK_BYTES / 512) + 1;
   localparam int PW = 32 + SW;
   localparam logic [IW-1:0] LAST_IDX = IW'(PAGES - 1);

   fsm_state_type state_ff, state_in;

   // slot directory
   logic [PAGES-1:0] valid_ff;
   logic [7:0]       dev_ff [PAGES];
   logic [31:0]      blk_ff [PAGES];
   logic [SW-1:0]    sect_ff [PAGES];
   logic [7:0]       pins_ff [PAGES];
   logic [IW-1:0]    rank_ff [PAGES];

   logic [31:0] hit_cnt_ff, miss_cnt_ff, evict_cnt_ff, wb_cnt_ff;
   logic [31:0] last_lba_ff;
   logic        range_on_ff;

   // latched request
   logic [2:0]  rq_type_ff;
   logic [7:0]  rq_dev_ff;
   logic [31:0] rq_blk_ff;
   logic [15:0] rq_bytes_ff;

   // scan results
   logic [IW-1:0] idx_ff;
   logic          hit_ff, free_ff, vic_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, vic_idx_ff;
   logic [IW-1:0] vic_rank_ff;
   logic [IW-1:0] tgt_ff;

   // shared multiplier
   logic [31:0]   mul_a_ff;
   logic [SW-1:0] mul_b_ff;
   logic [PW-1:0] prod_ff;

   // pending items
   logic [1:0]  cmd_kind_ff;
   logic [3:0]  cmd_cnt_ff;
   logic [3:0]  st_ff;
   logic [3:0]  stslot_ff;

   logic        rsp_valid_ff;
   logic [1:0]  o_kind_ff;
   logic [3:0]  o_status_ff, o_slot_ff, o_cnt_ff;
   logic [31:0] o_lba_ff, o_hit_ff, o_miss_ff, o_evict_ff, o_wb_ff;
   logic        o_last_ff;

   logic out_free, load_out, cur_match, bad_size, fill_ovf, fill_oor;
   logic [SW-1:0] spb;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = ((state_ff == S_CMD) || (state_ff == S_STAT)) && out_free;
   assign cur_match = valid_ff[idx_ff] && dev_ff[idx_ff] == rq_dev_ff &&
                      blk_ff[idx_ff] == rq_blk_ff;
   assign spb       = SW'(rq_bytes_ff >> SECTOR_SHIFT);
   assign bad_size  = (rq_bytes_ff == 16'd0) || (rq_bytes_ff[SECTOR_SHIFT-1:0] != '0) ||
                      (32'(rq_bytes_ff) > 32'(MAX_BLOCK_BYTES));
   assign fill_ovf  = |prod_ff[PW-1:32];
   assign fill_oor  = ({1'b0, prod_ff[31:0]} + 33'(spb)) > {1'b0, last_lba_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SCAN;
         S_SCAN:   if (idx_ff == LAST_IDX) state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_STAT;
            if (rq_type_ff == REQ_GET && !hit_ff && !bad_size) state_in = S_MUL;
            if (rq_type_ff == REQ_MARK_DIRTY && hit_ff) state_in = S_MUL;
         end
         S_MUL:    state_in = (rq_type_ff == REQ_GET) ? S_CHECK : S_CMD;
         S_CHECK: begin
            state_in = S_STAT;
            if (!(range_on_ff && (fill_ovf || fill_oor)) && (free_ff || vic_ff))
               state_in = S_FILL;
         end
         S_FILL:   state_in = S_CMD;
         S_CMD:    if (out_free) state_in = S_STAT;
         S_STAT:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // parallel recency update helpers, one lane per slot
   function automatic logic [IW-1:0] unlink_rank(logic [IW-1:0] r, logic [IW-1:0] rs,
                                                  logic v, logic self);
      logic [IW-1:0] res;
      res = r;
      if (self) res = '0;
      else if (v && r > rs) res = r - 1'b1;
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         wb_cnt_ff    <= '0;
         last_lba_ff  <= 32'hFFFF_FFFF;
         range_on_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PAGES; i++) begin
            rank_ff[i] <= '0;
            pins_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LAST_LBA: last_lba_ff <= csr_wdata;
               CSR_RANGE_ON: range_on_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               rq_type_ff  <= req_type;
               rq_dev_ff   <= req_device_id;
               rq_blk_ff   <= req_block_number;
               rq_bytes_ff <= req_block_bytes;
               idx_ff  <= '0;
               hit_ff  <= 1'b0;
               free_ff <= 1'b0;
               vic_ff  <= 1'b0;
               st_ff     <= ST_HIT;
               stslot_ff <= '0;
            end
            S_SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (cur_match && !hit_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= idx_ff;
               end
               if (!valid_ff[idx_ff] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= idx_ff;
               end
               if (pins_ff[idx_ff] == 8'd0 && (!vic_ff || rank_ff[idx_ff] > vic_rank_ff)) begin
                  vic_ff      <= 1'b1;
                  vic_idx_ff  <= idx_ff;
                  vic_rank_ff <= rank_ff[idx_ff];
               end
               // invalidate device drops matching unpinned slots in scan order
               if (rq_type_ff == REQ_INV_DEV && valid_ff[idx_ff] &&
                   dev_ff[idx_ff] == rq_dev_ff && pins_ff[idx_ff] == 8'd0) begin
                  valid_ff[idx_ff] <= 1'b0;
                  for (int i = 0; i < PAGES; i++)
                     rank_ff[i] <= unlink_rank(rank_ff[i], rank_ff[idx_ff], valid_ff[i],
                                               IW'(i) == idx_ff);
               end
            end
            S_DECIDE: begin
               // only the per-block requests report the matched slot
               stslot_ff <= (hit_ff && rq_type_ff inside {REQ_GET, REQ_PUT, REQ_MARK_DIRTY,
                                                          REQ_INV_BLOCK}) ?
                            4'(hit_idx_ff) : 4'd0;
               case (rq_type_ff)
                  REQ_GET: begin
                     if (hit_ff) begin
                        hit_cnt_ff <= hit_cnt_ff + 1'b1;
                        if (pins_ff[hit_idx_ff] < PIN_MAX)
                           pins_ff[hit_idx_ff] <= pins_ff[hit_idx_ff] + 1'b1;
                        for (int i = 0; i < PAGES; i++) begin
                           if (IW'(i) == hit_idx_ff) rank_ff[i] <= '0;
                           else if (valid_ff[i] && rank_ff[i] < rank_ff[hit_idx_ff])
                              rank_ff[i] <= rank_ff[i] + 1'b1;
                        end
                     end else begin
                        miss_cnt_ff <= miss_cnt_ff + 1'b1;
                        if (bad_size) st_ff <= ST_BAD_SIZE;
                        mul_a_ff <= rq_blk_ff;
                        mul_b_ff <= spb;
                     end
                  end
                  REQ_PUT: begin
                     if (!hit_ff) st_ff <= ST_NOT_CACHED;
                     else if (pins_ff[hit_idx_ff] == 8'd0) st_ff <= ST_PIN_UNDERFLOW;
                     else pins_ff[hit_idx_ff] <= pins_ff[hit_idx_ff] - 1'b1;
                  end
                  REQ_MARK_DIRTY: begin
                     // dirty is written back at once, so it never persists
                     if (!hit_ff) st_ff <= ST_NOT_CACHED;
                     else begin
                        wb_cnt_ff   <= wb_cnt_ff + 1'b1;
                        mul_a_ff    <= blk_ff[hit_idx_ff];
                        mul_b_ff    <= sect_ff[hit_idx_ff];
                        cmd_kind_ff <= KIND_WRITE;
                        cmd_cnt_ff  <= 4'(sect_ff[hit_idx_ff]);
                        tgt_ff      <= hit_idx_ff;
                     end
                  end
                  REQ_INV_BLOCK: begin
                     if (!hit_ff) st_ff <= ST_NOT_CACHED;
                     else if (pins_ff[hit_idx_ff] != 8'd0) st_ff <= ST_PINNED_REFUSED;
                     else begin
                        valid_ff[hit_idx_ff] <= 1'b0;
                        for (int i = 0; i < PAGES; i++)
                           rank_ff[i] <= unlink_rank(rank_ff[i], rank_ff[hit_idx_ff],
                                                     valid_ff[i], IW'(i) == hit_idx_ff);
                     end
                  end
                  default: ;
               endcase
            end
            S_MUL: begin
               prod_ff <= PW'(mul_a_ff) * PW'(mul_b_ff);
            end
            S_CHECK: begin
               if (range_on_ff && fill_ovf) st_ff <= ST_LBA_OVERFLOW;
               else if (range_on_ff && fill_oor) st_ff <= ST_OUT_OF_RANGE;
               else if (free_ff) tgt_ff <= free_idx_ff;
               else if (vic_ff) begin
                  tgt_ff <= vic_idx_ff;
                  evict_cnt_ff <= evict_cnt_ff + 1'b1;
                  valid_ff[vic_idx_ff] <= 1'b0;
                  for (int i = 0; i < PAGES; i++)
                     rank_ff[i] <= unlink_rank(rank_ff[i], rank_ff[vic_idx_ff],
                                               valid_ff[i], IW'(i) == vic_idx_ff);
               end else st_ff <= ST_ALL_PINNED;
            end
            S_FILL: begin
               valid_ff[tgt_ff] <= 1'b1;
               dev_ff[tgt_ff]   <= rq_dev_ff;
               blk_ff[tgt_ff]   <= rq_blk_ff;
               sect_ff[tgt_ff]  <= spb;
               pins_ff[tgt_ff]  <= 8'd1;
               for (int i = 0; i < PAGES; i++) begin
                  if (IW'(i) == tgt_ff) rank_ff[i] <= '0;
                  else if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + 1'b1;
               end
               cmd_kind_ff <= KIND_READ;
               cmd_cnt_ff  <= 4'(spb);
               st_ff       <= ST_FILLED;
               stslot_ff   <= 4'(tgt_ff);
            end
            S_CMD: begin
               if (out_free) begin
                  o_kind_ff    <= cmd_kind_ff;
                  o_status_ff  <= ST_HIT;
                  o_slot_ff    <= 4'(tgt_ff);
                  o_lba_ff     <= prod_ff[31:0];
                  o_cnt_ff     <= cmd_cnt_ff;
                  o_last_ff    <= 1'b0;
                  o_hit_ff     <= hit_cnt_ff;
                  o_miss_ff    <= miss_cnt_ff;
                  o_evict_ff   <= evict_cnt_ff;
                  o_wb_ff      <= wb_cnt_ff;
               end
            end
            S_STAT: begin
               if (out_free) begin
                  o_kind_ff    <= KIND_STATUS;
                  o_status_ff  <= st_ff;
                  o_slot_ff    <= stslot_ff;
                  o_lba_ff     <= '0;
                  o_cnt_ff     <= '0;
                  o_last_ff    <= 1'b1;
                  o_hit_ff     <= hit_cnt_ff;
                  o_miss_ff    <= miss_cnt_ff;
                  o_evict_ff   <= evict_cnt_ff;
                  o_wb_ff      <= wb_cnt_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item_kind       = o_kind_ff;
   assign rsp_status          = o_status_ff;
   assign rsp_slot            = o_slot_ff;
   assign rsp_lba             = o_lba_ff;
   assign rsp_sector_count    = o_cnt_ff;
   assign rsp_is_last         = o_last_ff;
   assign rsp_hit_count       = o_hit_ff;
   assign rsp_miss_count      = o_miss_ff;
   assign rsp_eviction_count  = o_evict_ff;
   assign rsp_writeback_count = o_wb_ff;

endmodule
